/* rtl/core/rau_pkg.sv */
// Package for the rational arithmetic unit: operation and status codes,
// control struct (start, busy). No dependencies.
package rau_pkg;
   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DIVZERO  = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_RSVD     = 2'd3
   } status_type;

   typedef struct packed {
      logic start;
      logic busy;
   } ctl_type;
endpackage

/* rtl/core/rau_gcd_div.sv */
// Binary gcd followed by two restoring divisions by the gcd, one shift/subtract
// step a cycle. Depends on rau_pkg.
module rau_gcd_div #(
   parameter int unsigned W2 = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  rau_pkg::ctl_type ctl,
   input  logic [W2-1:0] num,
   input  logic [W2-1:0] den,
   output logic          done,
   output logic [W2-1:0] q_num,
   output logic [W2-1:0] q_den
);
   import rau_pkg::*;
   localparam int unsigned CW = $clog2(W2 + 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_GCD  = 5'b00010,
      S_DIVN = 5'b00100,
      S_DIVD = 5'b01000,
      S_DONE = 5'b10000
   } gstate_type;

   gstate_type state_ff, state_in;
   logic [W2-1:0] x_ff, x_in, y_ff, y_in;
   logic [CW-1:0] k_ff, k_in;       // common power of two
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W2-1:0] g_ff, g_in;
   logic [W2:0]   rem_ff, rem_in;
   logic [W2-1:0] quo_ff, quo_in;
   logic [W2-1:0] qn_ff, qn_in, qd_ff, qd_in;
   logic [W2-1:0] dvd_ff, dvd_in;
   logic [W2:0]   trial;
   logic [W2-1:0] diff;

   always_comb begin
      state_in = state_ff;
      x_in = x_ff; y_in = y_ff; k_in = k_ff; cnt_in = cnt_ff; g_in = g_ff;
      rem_in = rem_ff; quo_in = quo_ff; qn_in = qn_ff; qd_in = qd_ff;
      dvd_in = dvd_ff;
      trial = {rem_ff[W2-1:0], dvd_ff[W2-1]};
      diff = (x_ff > y_ff) ? (x_ff - y_ff) : (y_ff - x_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               x_in = num; y_in = den; k_in = '0; state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (x_ff == y_ff) begin
               g_in = x_ff << k_ff;
               dvd_in = num; rem_in = '0; cnt_in = CW'(W2);
               state_in = S_DIVN;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1; y_in = y_ff >> 1; k_in = k_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff > y_ff) begin
               x_in = diff >> 1;
            end else begin
               y_in = diff >> 1;
            end
         end
         S_DIVN, S_DIVD: begin
            dvd_in = dvd_ff << 1;
            if (trial >= {1'b0, g_ff}) begin
               rem_in = trial - {1'b0, g_ff};
               quo_in = {quo_ff[W2-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[W2-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               if (state_ff == S_DIVN) begin
                  qn_in = quo_in; dvd_in = den; rem_in = '0;
                  cnt_in = CW'(W2); state_in = S_DIVD;
               end else begin
                  qd_in = quo_in; state_in = S_DONE;
               end
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
      x_ff <= x_in; y_ff <= y_in; k_ff <= k_in; cnt_ff <= cnt_in; g_ff <= g_in;
      rem_ff <= rem_in; quo_ff <= quo_in; qn_ff <= qn_in; qd_ff <= qd_in;
      dvd_ff <= dvd_in;
   end

   assign done  = (state_ff == S_DONE);
   assign q_num = qn_ff;
   assign q_den = qd_ff;
   wire unused_busy = ctl.busy;

   property p_gcd_nonzero;
      @(posedge clock) disable iff (reset)
         (state_ff == S_DIVN && $past(state_ff) == S_GCD) |-> (g_ff != '0);
   endproperty
   a_gcd_nonzero: assert property (p_gcd_nonzero) else $error("gcd zero");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("done held");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (ctl.start && state_ff == S_IDLE) |=> (state_ff == S_GCD))
      else $error("start lost");
endmodule

/* rtl/core/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit: operand capture, cross products,
// result check and output register. Depends on rau_pkg and rau_gcd_div.
//
// One transaction at a time. A request passes through T_MUL1, T_MUL2 and
// T_MUL3 for the cross products, then a binary gcd (one compare and
// subtract or shift per cycle) and two restoring divisions by the gcd in
// the shared gcd/divider unit.
// Errors (zero denominator, division by zero) and zero
// results skip the gcd. The result waits in an
// output register; req_ready rises again once it is taken.
module rational_arithmetic_unit #(
   parameter int unsigned WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic signed [31:0] req_a_numerator,
   input  logic signed [31:0] req_a_denominator,
   input  logic signed [31:0] req_b_numerator,
   input  logic signed [31:0] req_b_denominator,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_result_numerator,
   output logic [30:0] rsp_result_denominator,
   output logic [1:0]  rsp_status
);
   import rau_pkg::*;
   localparam int unsigned W2 = 2 * WIDTH;

   typedef enum logic [5:0] {
      T_IDLE = 6'b000001,
      T_MUL1 = 6'b000010,   // first product
      T_MUL2 = 6'b000100,   // second product
      T_MUL3 = 6'b001000,   // denominator product, error and zero checks
      T_RED  = 6'b010000,   // gcd and divisions running
      T_OUT  = 6'b100000
   } tstate_type;

   tstate_type st_ff, st_in;
   op_type kind_ff;
   logic [WIDTH-1:0] n1_ff, d1_ff, n2_ff, d2_ff;    // magnitudes
   logic s1_ff, s2_ff;
   logic [W2-1:0] t1_ff, t2_ff, num_ff, den_ff, prod;
   logic [WIDTH-1:0] ma, mb;
   logic neg_ff;
   logic red_start;
   ctl_type ctl;
   logic g_done;
   logic [W2-1:0] q_num, q_den;
   logic signed [31:0] onum_ff;
   logic [30:0] oden_ff;
   status_type ost_ff;
   logic ovalid_ff;

   function automatic logic [WIDTH-1:0] mag(input logic [31:0] v);
      logic [WIDTH-1:0] w;
      w = v[WIDTH-1:0];
      return w[WIDTH-1] ? (~w + 1'b1) : w;
   endfunction

   // One shared multiplier, operands picked by state.
   always_comb begin
      unique case (st_ff)
         T_MUL1:  begin ma = n1_ff; mb = (kind_ff == OP_MUL) ? n2_ff : d2_ff; end
         T_MUL2:  begin ma = n2_ff; mb = d1_ff; end
         default: begin ma = d1_ff; mb = (kind_ff == OP_DIV) ? n2_ff : d2_ff; end
      endcase
      prod = W2'(ma) * W2'(mb);
   end

   logic s2e;
   assign s2e = (kind_ff == OP_SUB) ? ~s2_ff : s2_ff;

   logic [W2-1:0] half;
   logic ovf, divz, zero_num;
   assign half = W2'(1) << (WIDTH - 1);
   assign ovf  = (q_den > half - 1'b1) || (neg_ff ? (q_num > half) : (q_num > half - 1'b1));
   assign divz = (d1_ff == '0) || (d2_ff == '0) || (kind_ff == OP_DIV && n2_ff == '0);
   assign zero_num = (num_ff == '0);

   always_comb begin
      st_in = st_ff;
      red_start = 1'b0;
      unique case (st_ff)
         T_IDLE: if (req_valid && req_ready) st_in = T_MUL1;
         T_MUL1: st_in = T_MUL2;
         T_MUL2: st_in = T_MUL3;
         // errors and zero results skip the reduction
         T_MUL3: st_in = (divz || zero_num) ? T_OUT : T_RED;
         T_RED:  begin
            red_start = 1'b1;
            if (g_done) st_in = T_OUT;
         end
         T_OUT:  st_in = T_IDLE;
         default: st_in = T_IDLE;
      endcase
   end

   assign ctl.start = red_start;
   assign ctl.busy  = (st_ff != T_IDLE);
   assign req_ready = (st_ff == T_IDLE) && !ovalid_ff;

   logic [WIDTH-1:0] qn_w;
   assign qn_w = q_num[WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= T_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == T_OUT) ovalid_ff <= 1'b1;
         else if (rsp_ready) ovalid_ff <= 1'b0;
      end
      if (st_ff == T_IDLE && req_valid && req_ready) begin
         kind_ff <= op_type'(req_kind);
         n1_ff <= mag(req_a_numerator);
         d1_ff <= mag(req_a_denominator);
         n2_ff <= mag(req_b_numerator);
         d2_ff <= mag(req_b_denominator);
         s1_ff <= req_a_numerator[WIDTH-1] ^ req_a_denominator[WIDTH-1];
         s2_ff <= req_b_numerator[WIDTH-1] ^ req_b_denominator[WIDTH-1];
      end
      if (st_ff == T_MUL1) t1_ff <= prod;
      if (st_ff == T_MUL2) t2_ff <= prod;
      if (st_ff == T_MUL2) begin
         // numerator formed here for every kind; den in MUL3
         if (kind_ff == OP_MUL || kind_ff == OP_DIV) begin
            num_ff <= t1_ff; neg_ff <= s1_ff ^ s2_ff;
         end else if (s1_ff == s2e) begin
            num_ff <= t1_ff + prod; neg_ff <= s1_ff;
         end else if (t1_ff >= prod) begin
            num_ff <= t1_ff - prod; neg_ff <= s1_ff;
         end else begin
            num_ff <= prod - t1_ff; neg_ff <= s2e;
         end
      end
      if (st_ff == T_MUL3) begin
         den_ff <= prod;
         if (divz) begin
            onum_ff <= '0; oden_ff <= 31'd1; ost_ff <= ST_DIVZERO;
         end else if (zero_num) begin
            onum_ff <= '0; oden_ff <= 31'd1; ost_ff <= ST_OK;
         end
      end
      if (st_ff == T_RED && g_done) begin
         if (ovf) begin
            onum_ff <= '0; oden_ff <= 31'd1; ost_ff <= ST_OVERFLOW;
         end else begin
            onum_ff <= 32'(signed'(neg_ff ? (~qn_w + 1'b1) : qn_w));
            oden_ff <= 31'(q_den);
            ost_ff  <= ST_OK;
         end
      end
   end

   // gcd unit sees start for one cycle only on entry to T_RED
   logic red_first_ff;
   always_ff @(posedge clock) begin
      if (reset) red_first_ff <= 1'b0;
      else       red_first_ff <= (st_ff == T_MUL3) && !(divz || zero_num);
   end
   ctl_type gctl;
   assign gctl.start = red_first_ff;
   assign gctl.busy  = ctl.busy & ctl.start;

   rau_gcd_div #(.W2(W2)) u_gcd (
      .clock (clock), .reset (reset), .ctl (gctl),
      .num (num_ff), .den (den_ff),
      .done (g_done), .q_num (q_num), .q_den (q_den)
   );

   assign rsp_valid = ovalid_ff;
   assign rsp_result_numerator = onum_ff;
   assign rsp_result_denominator = oden_ff;
   assign rsp_status = ost_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != T_IDLE) |-> !req_ready) else $error("ready while busy");
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_denominator != '0)) else $error("zero den");
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
      (rsp_result_numerator == 0 && rsp_result_denominator == 31'd1))
      else $error("bad error form");
   a_out_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (st_ff == T_OUT) |=> rsp_valid) else $error("result lost");
endmodule

/* tb/rational_arithmetic_unit_tb.sv */
// Testbench for rational_arithmetic_unit: directed and random fraction
// operations checked against an in-bench exact arithmetic predictor.
// Depends on rau_pkg and the rational_arithmetic_unit RTL.
module rational_arithmetic_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rau_pkg::*;

   localparam int unsigned WIDTH = 32;
   localparam longint unsigned LIMIT = 3000000;
   localparam int unsigned HOLD_CYCLES = 400;

   typedef struct packed {
      logic signed [31:0] num;
      logic [30:0]        den;
      status_type         st;
   } frac_result;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_kind = '0;
   logic signed [31:0] req_a_numerator = '0;
   logic signed [31:0] req_a_denominator = '0;
   logic signed [31:0] req_b_numerator = '0;
   logic signed [31:0] req_b_denominator = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_result_numerator;
   logic [30:0] rsp_result_denominator;
   logic [1:0] rsp_status;

   frac_result expected_fracs[$];
   int unsigned errors = 0;
   longint unsigned cycle_count = 0;
   bit quiet_rx = 1'b0;     // no random stalls on the result side
   bit quiet_tx = 1'b0;     // no random gaps on the request side
   bit hold_rx = 1'b0;      // request a long receiver hold-off
   int unsigned hold_cnt = 0; // hold-off cycles counted so far

   rational_arithmetic_unit #(.WIDTH(WIDTH)) dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("rational_arithmetic_unit: mismatch");
         $finish;
      end
   end

   // sign/magnitude view of a WIDTH-bit operand
   function automatic logic [63:0] magnitude(input logic [31:0] raw, output bit neg);
      logic [63:0] v;
      v = 64'(raw) & ((64'd1 << WIDTH) - 1);
      neg = v[WIDTH-1];
      return neg ? (64'd1 << WIDTH) - v : v;
   endfunction

   function automatic frac_result reduce_fraction(input op_type op,
         input logic [31:0] an, ad, bn, bd);
      logic [63:0] n1, d1, n2, d2, t1, t2, num, den, g, x, y, r, half;
      bit sn1, sd1, sn2, sd2, s1, s2, s2e, neg;
      frac_result res;
      res = '{num: '0, den: 31'd1, st: ST_OK};
      n1 = magnitude(an, sn1);
      d1 = magnitude(ad, sd1);
      n2 = magnitude(bn, sn2);
      d2 = magnitude(bd, sd2);
      s1 = sn1 != sd1;
      s2 = sn2 != sd2;
      if (d1 == 0 || d2 == 0 || (op == OP_DIV && n2 == 0)) begin
         res.st = ST_DIVZERO;
         return res;
      end
      case (op)
         OP_ADD, OP_SUB: begin
            t1 = n1 * d2;
            t2 = n2 * d1;
            s2e = (op == OP_SUB) ? !s2 : s2;
            den = d1 * d2;
            if (s1 == s2e) begin
               num = t1 + t2; neg = s1;
            end else if (t1 >= t2) begin
               num = t1 - t2; neg = s1;
            end else begin
               num = t2 - t1; neg = s2e;
            end
         end
         OP_MUL: begin
            num = n1 * n2; den = d1 * d2; neg = s1 != s2;
         end
         default: begin
            num = n1 * d2; den = d1 * n2; neg = s1 != s2;
         end
      endcase
      if (num == 0) return res;
      x = num;
      y = den;
      while (y != 0) begin
         r = x % y; x = y; y = r;
      end
      g = x;
      num = num / g;
      den = den / g;
      half = 64'd1 << (WIDTH - 1);
      if (den > half - 1 || (neg ? num > half : num > half - 1)) begin
         res.st = ST_OVERFLOW;
         return res;
      end
      res.num = neg ? 32'(-num) : 32'(num);
      res.den = 31'(den);
      return res;
   endfunction

   // one request transaction; valid stays up until accepted and drops only
   // while the sender idles
   task automatic send_fraction_op(input op_type op, input logic [31:0] an, ad, bn, bd);
      while (!quiet_tx && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= op;
      req_a_numerator <= an;
      req_a_denominator <= ad;
      req_b_numerator <= bn;
      req_b_denominator <= bd;
      do @(posedge clock); while (!req_ready);
      expected_fracs.push_back(reduce_fraction(op, an, ad, bn, bd));
   endtask

   // result side ready, with random stalls and the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_rx && hold_cnt < HOLD_CYCLES) begin
         hold_cnt <= hold_cnt + 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet_rx || ($urandom_range(99) >= 10);
      end
   end

   always @(posedge clock) begin
      frac_result exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_fracs.size() == 0) begin
            $error("unexpected transaction num=%0d", rsp_result_numerator);
            errors++;
         end else begin
            exp_r = expected_fracs.pop_front();
            if (rsp_result_numerator !== exp_r.num) begin
               $error("result_numerator exp %0d got %0d", exp_r.num, rsp_result_numerator);
               errors++;
            end
            if (rsp_result_denominator !== exp_r.den) begin
               $error("result_denominator exp %0d got %0d", exp_r.den,
                      rsp_result_denominator);
               errors++;
            end
            if (rsp_status !== exp_r.st) begin
               $error("status exp %0d got %0d", exp_r.st, rsp_status);
               errors++;
            end
         end
      end
   end

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(5))
         0: return 32'($signed($urandom_range(20)) - 10);
         1: return 32'($signed($urandom_range(2000)) - 1000);
         2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         3: return 32'($signed($urandom_range(131072)) - 65536);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_fraction_op(OP_ADD, 1, 2, 1, 3);
      send_fraction_op(OP_SUB, 1, 2, 1, 2);            // zero result
      send_fraction_op(OP_MUL, -3, 4, 8, -9);
      send_fraction_op(OP_DIV, 5, 7, -10, 21);
      send_fraction_op(OP_ADD, 1, 0, 1, 1);            // zero a denominator
      send_fraction_op(OP_SUB, 1, 1, 1, 0);            // zero b denominator
      send_fraction_op(OP_DIV, 1, 2, 0, 5);            // divisor zero
      send_fraction_op(OP_DIV, 1, 0, 0, 0);            // zero denominators first
      send_fraction_op(OP_MUL, 0, -5, 7, 3);
      send_fraction_op(OP_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1); // overflow
      send_fraction_op(OP_MUL, 32'h8000_0000, 1, 1, 1);  // most negative exact
      send_fraction_op(OP_MUL, 32'h8000_0000, 1, -1, 1); // overflow
      send_fraction_op(OP_DIV, 1, 32'h8000_0000, 1, 1);  // denominator too large
      send_fraction_op(OP_DIV, 1, 32'h8000_0000, -1, 1);
      send_fraction_op(OP_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF);
      send_fraction_op(OP_ADD, -1, -1, -1, -1);
      send_fraction_op(OP_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
      send_fraction_op(OP_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                       32'h7FFF_FFFF);
   endtask

   task automatic test_random(input int unsigned count);
      for (int unsigned i = 0; i < count; i++)
         send_fraction_op(op_type'($urandom_range(3)), rand_operand(), rand_operand(),
                          rand_operand(), rand_operand());
   endtask

   task automatic test_backpressure();
      hold_rx = 1'b1;
      test_random(20);
   endtask

   task automatic test_no_idle();
      quiet_rx = 1'b1;
      quiet_tx = 1'b1;
      test_random(150);
      quiet_rx = 1'b0;
      quiet_tx = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(600);
      test_backpressure();
      test_no_idle();
      test_random(530);
      req_valid <= 1'b0;
      while (expected_fracs.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (errors == 0)
         $display("rational_arithmetic_unit: match");
      else
         $display("rational_arithmetic_unit: mismatch");
      $finish;
   end
endmodule
